// ===== rtl/core/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared sizes, function codes and control types for the best-fit allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // table geometry
  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_WIDTH = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // port field widths
  localparam int FUNC_W   = 1;
  localparam int SLOT_W   = 4;
  localparam int AMT_W    = 16;
  localparam int CFG_W    = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 1'b0,
    FUNC_ALLOC = 1'b1
  } bfa_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } bfa_state_t;

  typedef struct packed {
    logic accept;   // word taken this cycle
    logic scan;     // step the table scan
    logic finish;   // register the result
  } bfa_cmd_t;

  typedef struct packed {
    logic is_req;     // incoming word is an allocation request
    logic scan_done;  // all live entries compared
  } bfa_status_t;

endpackage

// ===== rtl/core/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: accept a word, run the table scan for requests, then report.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bfa_pkg::bfa_status_t status,
  output bfa_pkg::bfa_cmd_t    cmd
);
  import bfa_pkg::*;

  bfa_state_t state_r;
  bfa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = status.is_req ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bfa_dp.sv =====
// ----------------------------------------------------------------------------
// bfa_dp
// Size table, used marks, count register, scan pipeline and result register.
// ----------------------------------------------------------------------------
module bfa_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bfa_pkg::bfa_cmd_t                   cmd,
  output bfa_pkg::bfa_status_t                status,
  input  logic [bfa_pkg::FUNC_W-1:0]          in_func,
  input  logic [bfa_pkg::SLOT_W-1:0]          in_slot,
  input  logic [bfa_pkg::AMT_W-1:0]           in_amount,
  input  logic                                cfg_valid,
  input  logic [bfa_pkg::CFG_W-1:0]           cfg_data,
  output logic                                out_valid,
  output logic                                out_granted,
  output logic [bfa_pkg::SLOT_W-1:0]          out_chosen_slot,
  output logic [bfa_pkg::AMT_W-1:0]           out_chosen_size
);
  import bfa_pkg::*;

  logic [SIZE_WIDTH-1:0] size_mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] used_r;
  logic [CNT_W-1:0]      count_r;

  logic [SIZE_WIDTH-1:0] amt_r;
  logic [CNT_W-1:0]      idx_r;
  logic                  cmp_vld_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic [SIZE_WIDTH-1:0] rd_data_r;
  logic                  found_r;
  logic [IDX_W-1:0]      best_r;
  logic [SIZE_WIDTH-1:0] best_size_r;

  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [AMT_W-1:0]      out_size_r;

  logic                  load_wr;
  logic                  issue;
  logic                  hit;

  assign load_wr = cmd.accept && (in_func == FUNC_LOAD) &&
                   (32'(in_slot) < MAX_BLOCKS);
  assign issue   = cmd.scan && (idx_r < count_r);
  assign hit     = cmp_vld_r && !used_r[cmp_idx_r] && (rd_data_r >= amt_r) &&
                   (!found_r || (rd_data_r < best_size_r));

  assign status.is_req    = (in_func == FUNC_ALLOC);
  assign status.scan_done = (idx_r >= count_r) && !cmp_vld_r;

  // size table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (load_wr) begin
      size_mem[IDX_W'(in_slot)] <= SIZE_WIDTH'(in_amount);
    end
    rd_data_r <= size_mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid) begin
      if (32'(cfg_data) > MAX_BLOCKS) begin
        count_r <= CNT_W'(MAX_BLOCKS);
      end else begin
        count_r <= CNT_W'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (load_wr) begin
      used_r[IDX_W'(in_slot)] <= 1'b0;
    end else if (cmd.finish && found_r) begin
      used_r[best_r] <= 1'b1;
    end
  end

  // scan: a read is issued, and its entry is compared in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (cmd.accept) begin
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      amt_r <= SIZE_WIDTH'(in_amount);
    end
    if (issue) begin
      cmp_idx_r <= idx_r[IDX_W-1:0];
    end
    if (hit) begin
      best_r      <= cmp_idx_r;
      best_size_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_granted_r <= found_r;
      out_slot_r    <= found_r ? SLOT_W'(best_r) : '0;
      out_size_r    <= found_r ? AMT_W'(best_size_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_chosen_slot = out_slot_r;
  assign out_chosen_size = out_size_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_granted_r) |-> used_r[IDX_W'(out_slot_r)])
    else $error("granted block not marked used");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (32'(cmp_idx_r) < 32'(count_r)))
    else $error("compare beyond live entries");

  a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && found_r) |-> (best_size_r >= amt_r))
    else $error("chosen block smaller than request");

endmodule

// ===== rtl/core/best_fit_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top
// Best-fit block allocator over a 16-entry size table with used marks.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A load goes from accept
// to the result state and its registered strobe; an allocation first runs the
// scan, which compares one table entry per cycle through the single read port
// of the size RAM and reads nothing when block_count is 0. A new word may be
// started in the cycle the previous result is strobed. Each result is on the
// out_ ports for exactly one cycle with out_valid high and must be taken then:
// it is not held. block_count is written through cfg_ valid and cfg_ready
// (always ready); the user must write it only while the block is idle, which
// the block itself does not enforce; values above the table depth saturate.
// Entries must be loaded before a request scans them.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [bfa_pkg::FUNC_W-1:0]   in_func,
  input  logic [bfa_pkg::SLOT_W-1:0]   in_slot,
  input  logic [bfa_pkg::AMT_W-1:0]    in_amount,
  output logic                         out_valid,
  output logic                         out_granted,
  output logic [bfa_pkg::SLOT_W-1:0]   out_chosen_slot,
  output logic [bfa_pkg::AMT_W-1:0]    out_chosen_size,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bfa_pkg::CFG_W-1:0]    cfg_data
);
  import bfa_pkg::*;

  bfa_cmd_t    cmd;
  bfa_status_t status;

  assign cfg_ready = 1'b1;

  bfa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  bfa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_func         (in_func),
    .in_slot         (in_slot),
    .in_amount       (in_amount),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_granted     (out_granted),
    .out_chosen_slot (out_chosen_slot),
    .out_chosen_size (out_chosen_size)
  );

endmodule

// ===== verif/bfa_alloc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfa_alloc_checker
// Watches the command, result and block_count channels of the best-fit
// allocator, predicts each grant from its own copy of the size table and
// used marks, and compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module bfa_alloc_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [bfa_pkg::FUNC_W-1:0]   in_func,
  input  logic [bfa_pkg::SLOT_W-1:0]   in_slot,
  input  logic [bfa_pkg::AMT_W-1:0]    in_amount,
  input  logic                         out_valid,
  input  logic                         out_granted,
  input  logic [bfa_pkg::SLOT_W-1:0]   out_chosen_slot,
  input  logic [bfa_pkg::AMT_W-1:0]    out_chosen_size,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [bfa_pkg::CFG_W-1:0]    cfg_data,
  output int                           mismatches,
  output int                           pending
);
  import bfa_pkg::*;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   slot;
    logic [AMT_W-1:0]    blk_size;
  } alloc_result_t;

  logic [SIZE_WIDTH-1:0] size_tab [MAX_BLOCKS];
  logic                  used_tab [MAX_BLOCKS];
  logic [CFG_W-1:0]      live_count;
  alloc_result_t         grant_q [$];
  int                    fails;

  initial begin
    mismatches = 0;
    pending    = 0;
    fails      = 0;
    live_count = '0;
  end

  // Updates the table copy; a load always answers with the all-zero word.
  function automatic alloc_result_t best_fit_grant(bfa_func_t fn, logic [SLOT_W-1:0] sl,
                                                   logic [AMT_W-1:0] amt);
    alloc_result_t r;
    logic          found;
    r     = '0;
    found = 1'b0;
    if (fn == FUNC_LOAD) begin
      size_tab[sl] = amt;
      used_tab[sl] = 1'b0;
      return r;
    end
    // strict less-than keeps the lowest index on equal sizes
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (i < live_count && !used_tab[i] && size_tab[i] >= amt &&
          (!found || size_tab[i] < r.blk_size)) begin
        found      = 1'b1;
        r.slot     = i[SLOT_W-1:0];
        r.blk_size = size_tab[i];
      end
    end
    if (found) begin
      r.granted         = 1'b1;
      used_tab[r.slot]  = 1'b1;
    end
    return r;
  endfunction

  task automatic report(string field, logic [AMT_W-1:0] want, logic [AMT_W-1:0] got);
    fails++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    alloc_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        size_tab[i] = '0;
        used_tab[i] = 1'b0;
      end
      live_count = '0;
      grant_q.delete();
    end else begin
      // result first: a new word may be taken on the edge that ends a strobe
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          report("unexpected result word, granted", '0, AMT_W'(out_granted));
        end else begin
          want = grant_q.pop_front();
          if (out_granted !== want.granted)
            report("granted", AMT_W'(want.granted), AMT_W'(out_granted));
          if (out_chosen_slot !== want.slot)
            report("chosen_slot", AMT_W'(want.slot), AMT_W'(out_chosen_slot));
          if (out_chosen_size !== want.blk_size)
            report("chosen_size", want.blk_size, out_chosen_size);
        end
      end
      if (start && !busy)
        grant_q.push_back(best_fit_grant(bfa_func_t'(in_func), in_slot, in_amount));
      if (cfg_valid && cfg_ready)
        live_count = (cfg_data > MAX_BLOCKS) ? CFG_W'(MAX_BLOCKS) : cfg_data;
    end
    pending    <= grant_q.size();
    mismatches <= fails;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the best-fit block allocator: a directed opening
// over empty and full tables, then random load/allocate phases under varying
// block_count settings with random idle gaps on the command side.
// ----------------------------------------------------------------------------
module tb_top;
  import bfa_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int WORD_TARGET = 1600;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   in_func;
  logic [SLOT_W-1:0]   in_slot;
  logic [AMT_W-1:0]    in_amount;
  logic                out_valid;
  logic                out_granted;
  logic [SLOT_W-1:0]   out_chosen_slot;
  logic [AMT_W-1:0]    out_chosen_size;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data;
  int                  mismatches;
  int                  pending;
  int                  cycles = 0;
  int                  words_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  best_fit_block_allocator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_slot         (in_slot),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_granted     (out_granted),
    .out_chosen_slot (out_chosen_slot),
    .out_chosen_size (out_chosen_size),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  bfa_alloc_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_slot         (in_slot),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_granted     (out_granted),
    .out_chosen_slot (out_chosen_slot),
    .out_chosen_size (out_chosen_size),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Holds start high until the word is taken; start stays high when no gap
  // follows, so back-to-back words never drop it.
  task automatic issue_word(bfa_func_t fn, logic [SLOT_W-1:0] sl, logic [AMT_W-1:0] amt,
                            int gap);
    start     <= 1'b1;
    in_func   <= fn;
    in_slot   <= sl;
    in_amount <= amt;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic write_count(logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_gap(logic no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // small values give ties, extremes hit the field edges
  function automatic logic [AMT_W-1:0] pick_amount(logic is_req);
    int r;
    r = $urandom_range(0, 99);
    if (r < (is_req ? 30 : 25))
      return AMT_W'($urandom_range(0, 7));
    if (r < 75)
      return AMT_W'($urandom_range(0, is_req ? 1100 : 1023));
    if (r < 90)
      return AMT_W'($urandom);
    return ($urandom_range(0, 1) == 1) ? '1 : '0;
  endfunction

  initial begin
    logic [AMT_W-1:0] seed_sizes [MAX_BLOCKS];
    logic [CFG_W-1:0] count_val;
    logic             no_idle;
    logic             is_req;
    int               phase;
    int               phase_words;

    seed_sizes = '{16'hFFFF, 16'h0000, 16'd100, 16'd100, 16'h8000, 16'd1, 16'h7FFF,
                   16'd50, 16'd200, 16'd300, 16'd400, 16'd500, 16'd600, 16'd700,
                   16'h5555, 16'hAAAA};
    rst_n     = 1'b0;
    start     = 1'b0;
    in_func   = FUNC_LOAD;
    in_slot   = '0;
    in_amount = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: everything refused, including a zero request
    issue_word(FUNC_ALLOC, 4'hF, 16'h0000, 0);
    issue_word(FUNC_ALLOC, 4'h0, 16'hFFFF, 2);
    // load every entry before any count lets a request scan it
    for (int i = 0; i < MAX_BLOCKS; i++)
      issue_word(FUNC_LOAD, SLOT_W'(i), seed_sizes[i], (i % 5 == 4) ? 3 : 0);
    write_count(CFG_W'(MAX_BLOCKS));
    issue_word(FUNC_ALLOC, 4'h0, 16'h0000, 0);   // zero request takes the size-0 entry
    issue_word(FUNC_ALLOC, 4'h5, 16'd100, 0);    // tie on 100, lowest index first
    issue_word(FUNC_ALLOC, 4'hA, 16'd100, 1);
    issue_word(FUNC_ALLOC, 4'hF, 16'hFFFF, 0);
    issue_word(FUNC_ALLOC, 4'h3, 16'hFFFF, 0);   // only 0xFFFF entry now used
    issue_word(FUNC_LOAD,  4'h0, 16'hFFFF, 0);   // reload clears the mark
    issue_word(FUNC_ALLOC, 4'h0, 16'hFFFE, 0);

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      case (phase)
        0:       count_val = 5'd31;               // saturates to the table depth
        1:       count_val = 5'd1;
        2:       count_val = 5'd0;
        3:       count_val = 5'd16;
        4:       count_val = 5'd17;
        default: count_val = CFG_W'($urandom_range(0, 31));
      endcase
      write_count(count_val);
      no_idle     = ($urandom_range(0, 3) == 0);
      phase_words = $urandom_range(40, 120);
      for (int n = 0; n < phase_words; n++) begin
        is_req = ($urandom_range(0, 99) < 55);
        issue_word(is_req ? FUNC_ALLOC : FUNC_LOAD, SLOT_W'($urandom_range(0, 15)),
                   pick_amount(is_req), pick_gap(no_idle));
      end
      phase++;
    end

    drain();
    // quiet window to catch any stray result word
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
